// ===== rtl/mts_pkg.sv =====
// package for the matrix transform stack: payload types, codes and constants
package mts_pkg;
	localparam int STACK_DEPTH = 16;
	localparam int LVL_W = $clog2(STACK_DEPTH);
	localparam int MAT_N = 4;
	localparam int MAT_ELEMS = 16;
	localparam int ADDR_W = LVL_W + 4;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;

	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_POP = 2'd1;
	localparam logic [1:0] FUNC_PEEK = 2'd2;
	localparam logic [1:0] FUNC_INIT = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] elem_index;
		logic signed [31:0] elem_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] out_index;
		logic signed [31:0] out_value;
		logic last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic stage_we;          // write staging element
		logic [3:0] stage_idx;
		logic mac_clear;         // start a new product element
		logic mac_en;            // accumulate one product term
		logic [1:0] mac_k;
		logic [3:0] elem;        // product element / peek element
		logic [LVL_W-1:0] src_lvl;
		logic store_we;          // write rounded product
		logic rd_en;             // read store for peek
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_valid;
		logic [31:0] rd_data;
		logic [31:0] mac_result;
	} dp_stat_t;

	function automatic logic [31:0] ident_elem(input logic [3:0] e);
		return (e[3:2] == e[1:0]) ? Q_ONE : 32'd0;
	endfunction
endpackage

// ===== rtl/mts_datapath.sv =====
// datapath: staging registers, matrix store, multiply-accumulate, rounding and saturation
module mts_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic [31:0] elem_value,
	input  mts_pkg::dp_cmd_t cmd,
	output mts_pkg::dp_stat_t stat
);
	import mts_pkg::*;

	localparam int MEM_DEPTH = STACK_DEPTH * MAT_ELEMS;

	logic [31:0] stage_q [MAT_ELEMS];
	logic [31:0] mem_q [MEM_DEPTH];
	logic [31:0] a_rd_q;
	logic [31:0] b_op_s1;
	logic a_lvl0_s1;
	logic [3:0] a_elem_s1;
	logic mul_en_s1, mul_en_s2, clr_s1, clr_s2;
	logic signed [63:0] prod_s2;
	logic signed [66:0] acc_q;
	logic rd_valid_q;

	logic [ADDR_W-1:0] a_addr, w_addr;
	logic [3:0] a_elem, b_elem;
	logic [31:0] a_op;
	logic signed [66:0] rnd;
	logic signed [50:0] shf;

	// product element r,c term k: a[r][k] * b[k][c]
	assign a_elem = cmd.rd_en ? cmd.elem : {cmd.elem[3:2], cmd.mac_k};
	assign b_elem = {cmd.mac_k, cmd.elem[1:0]};
	assign a_addr = {cmd.src_lvl, a_elem};
	assign w_addr = {LVL_W'(cmd.src_lvl + 1'b1), cmd.elem};

	always_ff @(posedge clk) begin
		if (cmd.stage_we)
			stage_q[cmd.stage_idx] <= elem_value;
		if (cmd.store_we)
			mem_q[w_addr] <= stat.mac_result;
		a_rd_q <= mem_q[a_addr];
		b_op_s1 <= stage_q[b_elem];
		a_elem_s1 <= a_elem;
		prod_s2 <= $signed(a_op) * $signed(b_op_s1);
	end

	// level zero reads identity through ident_elem; pushes write level one onward;
	// level zero itself is never written, so it always reads identity
	assign a_op = a_lvl0_s1 ? ident_elem(a_elem_s1) : a_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_en_s1 <= 1'b0;
			mul_en_s2 <= 1'b0;
			clr_s1 <= 1'b0;
			clr_s2 <= 1'b0;
			rd_valid_q <= 1'b0;
			a_lvl0_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			mul_en_s1 <= cmd.mac_en;
			mul_en_s2 <= mul_en_s1;
			clr_s1 <= cmd.mac_clear;
			clr_s2 <= clr_s1;
			rd_valid_q <= cmd.rd_en;
			a_lvl0_s1 <= (cmd.src_lvl == '0);
			if (mul_en_s2)
				acc_q <= (clr_s2 ? 67'sd0 : acc_q) + 67'(prod_s2);
		end
	end

	assign rnd = acc_q + 67'sd32768;
	assign shf = 51'(rnd >>> 16);
	always_comb begin
		if (shf > 51'sd2147483647)
			stat.mac_result = 32'h7fff_ffff;
		else if (shf < -51'sd2147483648)
			stat.mac_result = 32'h8000_0000;
		else
			stat.mac_result = shf[31:0];
	end

	assign stat.rd_valid = rd_valid_q;
	assign stat.rd_data = a_op;
endmodule

// ===== rtl/mts_ctrl.sv =====
// controller: sequences pushes, pops, peeks and init, drives the result register
module mts_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mts_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output mts_pkg::out_item_t out_item,
	output mts_pkg::dp_cmd_t cmd,
	input  mts_pkg::dp_stat_t stat
);
	import mts_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAC = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_PEEK = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;

	logic [2:0] state_q;
	logic [LVL_W-1:0] top_q;
	logic [3:0] elem_q;
	logic [1:0] k_q;
	logic [2:0] drain_q;
	logic [3:0] peek_q;
	logic peek_busy_q;
	logic out_valid_q;
	out_item_t out_q;
	logic acc_in, out_free;
	logic push_full, out_load;
	logic [1:0] in_status;

	assign out_free = !out_valid_q || out_ready;
	assign acc_in = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign push_full = (32'(top_q) + 32'd1 >= 32'(STACK_DEPTH));
	assign in_status = (in_item.func == FUNC_PUSH && in_item.elem_index == 4'd15 && push_full) ?
		ST_FULL : (in_item.func == FUNC_POP && top_q == '0) ? ST_EMPTY : ST_OK;

	always_comb begin
		unique case (state_q)
			S_IDLE: out_load = acc_in && ((in_item.func == FUNC_POP) ||
				(in_item.func == FUNC_INIT) ||
				(in_item.func == FUNC_PUSH && in_item.elem_index == 4'd15 && push_full));
			S_DRAIN: out_load = (drain_q == 3'd0) && (elem_q == 4'd15);
			S_PEEK: out_load = peek_busy_q && stat.rd_valid && out_free;
			default: out_load = 1'b0;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.src_lvl = top_q;
		cmd.elem = elem_q;
		cmd.mac_k = k_q;
		cmd.stage_idx = in_item.elem_index;
		cmd.stage_we = acc_in && (in_item.func == FUNC_PUSH);
		if (state_q == S_MAC) begin
			cmd.mac_en = 1'b1;
			cmd.mac_clear = (k_q == 2'd0);
		end
		// store the result of element elem_q once its last term has passed the store read, product and accumulator registers
		cmd.store_we = (state_q == S_DRAIN) && (drain_q == 3'd0);
		// keep reading the peek address so the data holds while stalled
		if (state_q == S_PEEK) begin
			cmd.elem = peek_q;
			cmd.rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q <= '0;
			elem_q <= '0;
			k_q <= '0;
			drain_q <= '0;
			peek_q <= '0;
			peek_busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						out_q <= '{status: in_status, out_index: 4'd0, out_value: 32'sd0,
							last: 1'b1};
						unique case (in_item.func)
							FUNC_PUSH: begin
								if (in_item.elem_index == 4'd15 && !push_full) begin
									elem_q <= '0;
									k_q <= '0;
									state_q <= S_MAC;
								end
							end
							FUNC_POP: begin
								if (top_q != '0)
									top_q <= top_q - 1'b1;
							end
							FUNC_PEEK: begin
								peek_q <= '0;
								peek_busy_q <= 1'b0;
								state_q <= S_PEEK;
							end
							FUNC_INIT: begin
								top_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_MAC: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						drain_q <= 3'd3;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (drain_q != 3'd0)
						drain_q <= drain_q - 1'b1;
					else if (elem_q == 4'd15) begin
						top_q <= top_q + 1'b1;
						state_q <= S_WAIT;
					end else begin
						elem_q <= elem_q + 1'b1;
						state_q <= S_MAC;
					end
				end
				S_PEEK: begin
					// one read in flight, then hold result until taken
					if (!peek_busy_q)
						peek_busy_q <= 1'b1;
					else if (stat.rd_valid && out_free) begin
						out_q <= '{status: ST_OK, out_index: peek_q,
							out_value: stat.rd_data, last: (peek_q == 4'd15)};
						peek_busy_q <= 1'b0;
						peek_q <= peek_q + 1'b1;
						if (peek_q == 4'd15)
							state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/matrix_transform_stack.sv =====
// top level of the matrix transform stack
// A stack of 16 4x4 Q16.16 matrices, level zero fixed at identity. Element pushes
// 0..14 only write staging; the push of element 15 runs 64 multiply-accumulates
// through one 32x32 multiplier, the terms of each element in turn and then a drain
// before its store. Peek emits 16 results, one store read at a time, each held in
// the registered store read until the result register is free. No clearing pass after reset.
module matrix_transform_stack (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mts_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output mts_pkg::out_item_t out_data
);
	import mts_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;

	mts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_data),
		.cmd(cmd), .stat(stat)
	);

	mts_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.elem_value(in_data.elem_value),
		.cmd(cmd), .stat(stat)
	);
endmodule

// ===== rtl/mts_checker.sv =====
// port checker for the matrix transform stack, bound to the top level
module mts_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  mts_pkg::in_item_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  mts_pkg::out_item_t out_data
);
	import mts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready || !out_valid || out_ready)
		else $error("input taken while output blocked");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status code");

	a_nonlast_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.status == ST_OK)
		else $error("error status on peek element");
endmodule

bind matrix_transform_stack mts_checker u_mts_checker (.*);

// ===== tb/sv/tb_top.sv =====
// testbench for the matrix transform stack: directed and random transactions against a predictor
`timescale 1ns / 1ps
module tb_top;
	import mts_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	matrix_transform_stack u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// predictor state
	logic [31:0] mstack [STACK_DEPTH][MAT_ELEMS];
	logic [31:0] staged [MAT_ELEMS];
	int unsigned top_lvl;

	out_item_t pending_results [$];
	int errors = 0;
	int hold_cycles = 0;  // forced receiver stall length, counted in the receiver process
	bit no_gaps = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_top failed");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	function automatic logic [31:0] q_mul_elem(input int r, input int c);
		longint hi, lo, p, lowp, res;
		hi = 0;
		lo = 0;
		for (int k = 0; k < MAT_N; k++) begin
			p = longint'($signed(mstack[top_lvl][r * MAT_N + k]))
				* longint'($signed(staged[k * MAT_N + c]));
			lowp = p & 64'hFFFF;
			hi += (p - lowp) / 65536;
			lo += lowp;
		end
		res = hi + (lo + 32'h8000) / 65536;
		if (res > 64'sd2147483647) res = 64'sd2147483647;
		if (res < -64'sd2147483648) res = -64'sd2147483648;
		return res[31:0];
	endfunction

	function automatic out_item_t mk(input logic [1:0] st, input logic [3:0] idx,
			input logic [31:0] val, input logic lst);
		out_item_t o;
		o.status = st;
		o.out_index = idx;
		o.out_value = val;
		o.last = lst;
		return o;
	endfunction

	function automatic void load_ident();
		for (int e = 0; e < MAT_ELEMS; e++)
			mstack[0][e] = (e / MAT_N == e % MAT_N) ? Q_ONE : 32'd0;
	endfunction

	function automatic void predict(input in_item_t it);
		logic [31:0] prod [MAT_ELEMS];
		case (it.func)
			FUNC_PUSH: begin
				staged[it.elem_index] = it.elem_value;
				if (it.elem_index == 4'd15) begin
					if (top_lvl + 1 >= STACK_DEPTH) begin
						pending_results.push_back(mk(ST_FULL, 4'd0, 32'd0, 1'b1));
					end else begin
						for (int e = 0; e < MAT_ELEMS; e++)
							prod[e] = q_mul_elem(e / MAT_N, e % MAT_N);
						top_lvl++;
						for (int e = 0; e < MAT_ELEMS; e++)
							mstack[top_lvl][e] = prod[e];
						pending_results.push_back(mk(ST_OK, 4'd0, 32'd0, 1'b1));
					end
				end
			end
			FUNC_POP: begin
				if (top_lvl == 0) begin
					pending_results.push_back(mk(ST_EMPTY, 4'd0, 32'd0, 1'b1));
				end else begin
					top_lvl--;
					pending_results.push_back(mk(ST_OK, 4'd0, 32'd0, 1'b1));
				end
			end
			FUNC_PEEK: begin
				for (int e = 0; e < MAT_ELEMS; e++)
					pending_results.push_back(mk(ST_OK, e[3:0], mstack[top_lvl][e], e == 15));
			end
			default: begin
				top_lvl = 0;
				load_ident();
				pending_results.push_back(mk(ST_OK, 4'd0, 32'd0, 1'b1));
			end
		endcase
	endfunction

	// valid stays high into a back-to-back transaction and drops only for a gap or a drain
	task automatic send(input logic [1:0] f, input logic [3:0] idx, input logic [31:0] val);
		int gap;
		in_item_t it;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.func = f;
		it.elem_index = idx;
		it.elem_value = val;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict(it);
	endtask

	// receiver and checker
	initial begin
		int stall;
		out_item_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = $urandom_range(0, 15);
			if ($urandom_range(0, 2) == 0) stall = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_results.size() == 0) begin
				report("unexpected result", out_data.out_value, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.status !== want.status)
					report("status", 32'(out_data.status), 32'(want.status));
				if (out_data.out_index !== want.out_index)
					report("out_index", 32'(out_data.out_index), 32'(want.out_index));
				if (out_data.out_value !== want.out_value)
					report("out_value", out_data.out_value, want.out_value);
				if (out_data.last !== want.last)
					report("last", 32'(out_data.last), 32'(want.last));
			end
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return Q_ONE;
			3: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_matrix(input int kind);
		logic [31:0] v;
		for (int e = 0; e < MAT_ELEMS; e++) begin
			case (kind)
				0: v = (e / 4 == e % 4) ? Q_ONE : 32'd0;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'h8000_0000;
				3: v = (e / 4 == e % 4) ? Q_ONE + $urandom_range(0, 32'hFFFF) :
					$urandom_range(0, 32'h1FFFF) - 32'h1_0000;
				default: v = rand_val();
			endcase
			send(FUNC_PUSH, e[3:0], v);
		end
	endtask

	task automatic test_basic_ops();
		send(FUNC_PEEK, 4'd0, 32'd0);
		send(FUNC_POP, 4'd0, 32'd0);
		push_matrix(0);
		push_matrix(1);
		send(FUNC_PEEK, 4'hF, 32'hFFFF_FFFF);
		push_matrix(2);
		send(FUNC_PEEK, 4'd0, 32'd0);
		send(FUNC_POP, 4'd0, 32'd0);
		send(FUNC_INIT, 4'h5, 32'h1234_5678);
		send(FUNC_POP, 4'd0, 32'd0);
		drain();
	endtask

	task automatic test_full_stack();
		for (int i = 0; i < STACK_DEPTH - 1; i++)
			push_matrix(3);
		send(FUNC_PEEK, 4'd0, 32'd0);
		// restage only the final element: a full push reuses staging
		send(FUNC_PUSH, 4'd15, rand_val());
		for (int i = 0; i < STACK_DEPTH; i++)
			send(FUNC_POP, 4'd0, 32'd0);
		drain();
	endtask

	task automatic test_backpressure();
		no_gaps = 1;
		hold_cycles = 400;
		repeat (6) send(FUNC_PEEK, 4'd0, 32'd0);
		push_matrix(4);
		no_gaps = 0;
		drain();
	endtask

	task automatic test_random();
		int n;
		n = 0;
		while (n < 16) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					push_matrix($urandom_range(3, 4));
					n += 16;
				end
				3: begin
					// stray element write, which runs a push when it hits element 15; staging already complete
					send(FUNC_PUSH, 4'($urandom_range(0, 15)), rand_val());
					n++;
				end
				4, 5: begin
					send(FUNC_POP, 4'($urandom), $urandom);
					n++;
				end
				6, 7, 8: begin
					send(FUNC_PEEK, 4'($urandom), $urandom);
					n++;
				end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						send(FUNC_INIT, 4'($urandom), $urandom);
						n++;
					end
				end
			endcase
			if ($urandom_range(0, 30) == 0) drain();
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		top_lvl = 0;
		load_ident();
		for (int e = 0; e < MAT_ELEMS; e++)
			staged[e] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_full_stack();
		test_backpressure();
		test_random();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

// ===== matrix_transform_stack.f =====
rtl/mts_pkg.sv
rtl/mts_datapath.sv
rtl/mts_ctrl.sv
rtl/matrix_transform_stack.sv
rtl/mts_checker.sv
tb/sv/tb_top.sv
